// ----- design/sslp_pkg.sv -----
// Package for the servo slew limiter with PWM duty computation.
// Holds the sequencer state type, register indexes and fixed constants.
// No dependencies.
package sslp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WMUL,
        ST_WFIN,
        ST_PLOAD,
        ST_PMUL,
        ST_DLOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CFG_SLEW_STEP    = 3'd0,
        CFG_SLEW_WAIT    = 3'd1,
        CFG_SETTLE_WAIT  = 3'd2,
        CFG_MS_PER_DEG   = 3'd3,
        CFG_MAX_MOVE     = 3'd4,
        CFG_MIN_PULSE    = 3'd5,
        CFG_MAX_PULSE    = 3'd6
    } t_cfg_idx;

    localparam logic [11:0] FULL_SCALE   = 12'd2880;
    localparam logic [11:0] NEAR_BAND    = 12'd8;
    localparam logic [11:0] MIN_SLEW     = 12'd45;
    localparam logic [11:0] RESET_ANGLE  = 12'd1440;
    localparam logic [5:0]  LAST_STEP    = 6'd63;
    localparam logic [4:0]  DIVISOR      = 5'd9;
    localparam logic [4:0]  MUL_TOP_BIT  = 5'd11;
    localparam logic [4:0]  DIV_TOP_BIT  = 5'd25;
    localparam logic [28:0] ROUND_ADD    = 29'd36;
    localparam logic [21:0] DUTY_MAX     = 22'd4095000;

    localparam logic [11:0] RST_SLEW_STEP   = 12'd0;
    localparam logic [15:0] RST_SLEW_WAIT   = 16'd20;
    localparam logic [15:0] RST_SETTLE_WAIT = 16'd200;
    localparam logic [15:0] RST_MS_PER_DEG  = 16'd768;
    localparam logic [15:0] RST_MAX_MOVE    = 16'd1000;
    localparam logic [11:0] RST_MIN_PULSE   = 12'd500;
    localparam logic [11:0] RST_MAX_PULSE   = 12'd2400;

endpackage

// ----- design/servo_slew_limiter_pwm_core.sv -----
// Servo slew limiter: turns a target angle into a run of drive steps with PWM duty and wait.
// Bit-serial multiply/accumulate and bit-serial divide-by-nine for the duty.
// Depends on sslp_pkg.
//
// Channel  Dir     Handshake                    Payload
// in       input   i_in_valid / o_in_stall      i_target_angle
// out      output  o_out_valid / i_out_stall    o_step_angle o_duty_ns o_drive o_wait_ms o_last
// cfg      input   i_cfg_we (write only)        i_cfg_index i_cfg_data
//
// Each result runs a bit-serial multiply for the duty numerator and a bit-serial divide by
// nine, plus step decision, load and emit steps.
// An unslewed move adds a bit-serial multiply for the move-time product.
// A move has at most 64 steps.
// Synchronous active-low reset restores the register defaults and a present angle of 90 deg.
// The last result may wait in the output register while the next request is accepted;
// a stalled output holds the sequencer at its emit step.
module servo_slew_limiter_pwm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [12:0] i_target_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_step_angle,
    output logic [21:0]        o_duty_ns,
    output logic               o_drive,
    output logic [16:0]        o_wait_ms,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    sslp_pkg::t_state r_state, n_state;

    logic [11:0] r_slew_step;
    logic [15:0] r_slew_wait;
    logic [15:0] r_settle_wait;
    logic [15:0] r_ms_per_deg;
    logic [15:0] r_max_move;
    logic [11:0] r_min_pulse;
    logic [11:0] r_max_pulse;

    logic [11:0] r_present, n_present;
    logic [11:0] r_target, n_target;
    logic [5:0]  r_step_cnt, n_step_cnt;
    logic [11:0] r_mla, n_mla;
    logic [11:0] r_mlb, n_mlb;
    logic [27:0] r_acc, n_acc;
    logic [25:0] r_div, n_div;
    logic [3:0]  r_rem, n_rem;
    logic [4:0]  r_bit_cnt, n_bit_cnt;
    logic [11:0] r_res_angle, n_res_angle;
    logic        r_res_drive, n_res_drive;
    logic [16:0] r_res_wait, n_res_wait;
    logic        r_res_last, n_res_last;

    logic        r_out_valid, n_out_valid;
    logic [11:0] r_out_angle, n_out_angle;
    logic [21:0] r_out_duty, n_out_duty;
    logic        r_out_drive, n_out_drive;
    logic [16:0] r_out_wait, n_out_wait;
    logic        r_out_last, n_out_last;

    logic in_take;
    logic out_take;

    assign o_in_stall   = (r_state != sslp_pkg::ST_IDLE);
    assign in_take      = i_in_valid && !o_in_stall;
    assign out_take     = r_out_valid && !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_step_angle = r_out_angle;
    assign o_duty_ns    = r_out_duty;
    assign o_drive      = r_out_drive;
    assign o_wait_ms    = r_out_wait;
    assign o_last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_step   <= sslp_pkg::RST_SLEW_STEP;
            r_slew_wait   <= sslp_pkg::RST_SLEW_WAIT;
            r_settle_wait <= sslp_pkg::RST_SETTLE_WAIT;
            r_ms_per_deg  <= sslp_pkg::RST_MS_PER_DEG;
            r_max_move    <= sslp_pkg::RST_MAX_MOVE;
            r_min_pulse   <= sslp_pkg::RST_MIN_PULSE;
            r_max_pulse   <= sslp_pkg::RST_MAX_PULSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sslp_pkg::CFG_SLEW_STEP:   r_slew_step   <= i_cfg_data[11:0];
                sslp_pkg::CFG_SLEW_WAIT:   r_slew_wait   <= i_cfg_data;
                sslp_pkg::CFG_SETTLE_WAIT: r_settle_wait <= i_cfg_data;
                sslp_pkg::CFG_MS_PER_DEG:  r_ms_per_deg  <= i_cfg_data;
                sslp_pkg::CFG_MAX_MOVE:    r_max_move    <= i_cfg_data;
                sslp_pkg::CFG_MIN_PULSE:   r_min_pulse   <= i_cfg_data[11:0];
                sslp_pkg::CFG_MAX_PULSE:   r_max_pulse   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sslp_pkg::ST_IDLE;
            r_present   <= sslp_pkg::RESET_ANGLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_step_cnt  <= n_step_cnt;
        r_mla       <= n_mla;
        r_mlb       <= n_mlb;
        r_acc       <= n_acc;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_bit_cnt   <= n_bit_cnt;
        r_res_angle <= n_res_angle;
        r_res_drive <= n_res_drive;
        r_res_wait  <= n_res_wait;
        r_res_last  <= n_res_last;
        r_out_angle <= n_out_angle;
        r_out_duty  <= n_out_duty;
        r_out_drive <= n_out_drive;
        r_out_wait  <= n_out_wait;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        logic        up;
        logic [11:0] mag;
        logic [11:0] slew;
        logic [11:0] move;
        logic [11:0] rest;
        logic [16:0] move_sum;
        logic [15:0] add_a;
        logic [15:0] add_b;
        logic [28:0] scaled;
        logic [4:0]  trial;

        n_state     = r_state;
        n_present   = r_present;
        n_target    = r_target;
        n_step_cnt  = r_step_cnt;
        n_mla       = r_mla;
        n_mlb       = r_mlb;
        n_acc       = r_acc;
        n_div       = r_div;
        n_rem       = r_rem;
        n_bit_cnt   = r_bit_cnt;
        n_res_angle = r_res_angle;
        n_res_drive = r_res_drive;
        n_res_wait  = r_res_wait;
        n_res_last  = r_res_last;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_out_angle = r_out_angle;
        n_out_duty  = r_out_duty;
        n_out_drive = r_out_drive;
        n_out_wait  = r_out_wait;
        n_out_last  = r_out_last;

        up       = (r_target > r_present);
        mag      = up ? (r_target - r_present) : (r_present - r_target);
        slew     = (r_slew_step < sslp_pkg::MIN_SLEW) ? sslp_pkg::MIN_SLEW : r_slew_step;
        move     = (mag < slew) ? mag : slew;
        rest     = mag - move;
        move_sum = {1'b0, r_settle_wait} + {1'b0, r_acc[27:12]};
        add_a    = (r_state == sslp_pkg::ST_WMUL) ? r_ms_per_deg : {4'd0, r_min_pulse};
        add_b    = {4'd0, r_max_pulse};
        scaled   = {r_acc[24:0], 4'd0} + {1'b0, r_acc[24:0], 3'd0} + {1'b0, r_acc}
                   + sslp_pkg::ROUND_ADD;
        trial    = {r_rem, r_div[25]};

        unique case (r_state)
            sslp_pkg::ST_IDLE: begin
                if (in_take) begin
                    if (i_target_angle[12]) begin
                        n_target = 12'd0;
                    end else if (i_target_angle[11:0] > sslp_pkg::FULL_SCALE) begin
                        n_target = sslp_pkg::FULL_SCALE;
                    end else begin
                        n_target = i_target_angle[11:0];
                    end
                    n_step_cnt = 6'd0;
                    n_state    = sslp_pkg::ST_DECIDE;
                end
            end
            sslp_pkg::ST_DECIDE: begin
                if (r_slew_step != 12'd0) begin
                    if (mag <= sslp_pkg::NEAR_BAND) begin
                        n_res_angle = r_present;
                        n_res_drive = 1'b0;
                        n_res_wait  = {1'b0, r_settle_wait};
                        n_res_last  = 1'b1;
                    end else begin
                        n_present   = up ? (r_present + move) : (r_present - move);
                        n_res_angle = n_present;
                        n_res_drive = 1'b1;
                        n_res_last  = (rest <= sslp_pkg::NEAR_BAND)
                                      || (r_step_cnt == sslp_pkg::LAST_STEP);
                        n_res_wait  = n_res_last
                                      ? ({1'b0, r_slew_wait} + {1'b0, r_settle_wait})
                                      : {1'b0, r_slew_wait};
                    end
                    n_state = sslp_pkg::ST_PLOAD;
                end else begin
                    n_present   = r_target;
                    n_res_angle = r_target;
                    n_res_drive = 1'b1;
                    n_res_last  = 1'b1;
                    n_mla       = mag;
                    n_mlb       = 12'd0;
                    n_acc       = 28'd0;
                    n_bit_cnt   = sslp_pkg::MUL_TOP_BIT;
                    n_state     = sslp_pkg::ST_WMUL;
                end
            end
            sslp_pkg::ST_WMUL, sslp_pkg::ST_PMUL: begin
                n_acc = {r_acc[26:0], 1'b0}
                        + (r_mla[11] ? {12'd0, add_a} : 28'd0)
                        + (r_mlb[11] ? {12'd0, add_b} : 28'd0);
                n_mla = {r_mla[10:0], 1'b0};
                n_mlb = {r_mlb[10:0], 1'b0};
                n_bit_cnt = r_bit_cnt - 5'd1;
                if (r_bit_cnt == 5'd0) begin
                    n_state = (r_state == sslp_pkg::ST_WMUL) ? sslp_pkg::ST_WFIN
                                                             : sslp_pkg::ST_DLOAD;
                end
            end
            sslp_pkg::ST_WFIN: begin
                n_res_wait = (move_sum > {1'b0, r_max_move}) ? {1'b0, r_max_move} : move_sum;
                n_state    = sslp_pkg::ST_PLOAD;
            end
            sslp_pkg::ST_PLOAD: begin
                n_mla     = sslp_pkg::FULL_SCALE - r_res_angle;
                n_mlb     = r_res_angle;
                n_acc     = 28'd0;
                n_bit_cnt = sslp_pkg::MUL_TOP_BIT;
                n_state   = sslp_pkg::ST_PMUL;
            end
            sslp_pkg::ST_DLOAD: begin
                n_div     = scaled[28:3];
                n_rem     = 4'd0;
                n_bit_cnt = sslp_pkg::DIV_TOP_BIT;
                n_state   = sslp_pkg::ST_DIV;
            end
            sslp_pkg::ST_DIV: begin
                if (trial >= sslp_pkg::DIVISOR) begin
                    n_rem = 4'(trial - sslp_pkg::DIVISOR);
                    n_div = {r_div[24:0], 1'b1};
                end else begin
                    n_rem = trial[3:0];
                    n_div = {r_div[24:0], 1'b0};
                end
                n_bit_cnt = r_bit_cnt - 5'd1;
                if (r_bit_cnt == 5'd0) begin
                    n_state = sslp_pkg::ST_EMIT;
                end
            end
            sslp_pkg::ST_EMIT: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_res_angle;
                    n_out_duty  = r_div[21:0];
                    n_out_drive = r_res_drive;
                    n_out_wait  = r_res_wait;
                    n_out_last  = r_res_last;
                    n_step_cnt  = r_step_cnt + 6'd1;
                    n_state     = r_res_last ? sslp_pkg::ST_IDLE : sslp_pkg::ST_DECIDE;
                end
            end
            default: begin
                n_state = sslp_pkg::ST_IDLE;
            end
        endcase
    end

    a_present_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_present <= sslp_pkg::FULL_SCALE)
        else $error("present angle beyond full scale");

    a_settle_only_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_drive) |-> r_out_last)
        else $error("settle-only result not marked last");

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= sslp_pkg::DUTY_MAX))
        else $error("duty out of range");

    a_request_starts_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == sslp_pkg::ST_DECIDE && r_step_cnt == 6'd0))
        else $error("accepted request did not start a move");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for servo_slew_limiter_pwm_core: directed and random target requests,
// with a step planner that predicts each drive step and its duty, wait and last flag.
// Depends on sslp_pkg and the core RTL.
module testbench;

    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         REPORT_LIMIT   = 10;
    localparam int         MAX_RUN        = 64;
    localparam int         SCALE          = int'(sslp_pkg::FULL_SCALE);
    localparam int         BAND           = int'(sslp_pkg::NEAR_BAND);
    localparam int         SLEW_FLOOR     = int'(sslp_pkg::MIN_SLEW);
    localparam logic [2:0] CFG_UNUSED     = 3'd7;
    localparam int         PHASE_ITEMS    = 110;

    typedef struct packed {
        logic [11:0] angle;
        logic [21:0] duty;
        logic        drive;
        logic [16:0] wait_ms;
        logic        lst;
    } t_step;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic signed [12:0] i_target_angle = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [11:0]        o_step_angle;
    logic [21:0]        o_duty_ns;
    logic               o_drive;
    logic [16:0]        o_wait_ms;
    logic               o_last;
    logic               i_cfg_we       = 1'b0;
    logic [2:0]         i_cfg_index    = '0;
    logic [15:0]        i_cfg_data     = '0;

    logic [11:0] slew_step_reg   = sslp_pkg::RST_SLEW_STEP;
    logic [15:0] slew_wait_reg   = sslp_pkg::RST_SLEW_WAIT;
    logic [15:0] settle_wait_reg = sslp_pkg::RST_SETTLE_WAIT;
    logic [15:0] ms_per_deg_reg  = sslp_pkg::RST_MS_PER_DEG;
    logic [15:0] max_move_reg    = sslp_pkg::RST_MAX_MOVE;
    logic [11:0] min_pulse_reg   = sslp_pkg::RST_MIN_PULSE;
    logic [11:0] max_pulse_reg   = sslp_pkg::RST_MAX_PULSE;
    int          servo_angle     = int'(sslp_pkg::RESET_ANGLE);

    t_step pending_steps[$];
    int    mismatch_count  = 0;
    int    stuck_cycles    = 0;
    int    sender_idle_pct = 0;
    int    recv_stall_pct  = 0;

    servo_slew_limiter_pwm_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_step_angle   (o_step_angle),
        .o_duty_ns      (o_duty_ns),
        .o_drive        (o_drive),
        .o_wait_ms      (o_wait_ms),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [21:0] duty_for(int angle);
        longint lo, span, num;
        lo   = longint'(min_pulse_reg);
        span = longint'(max_pulse_reg) - lo;
        num  = lo * 1000 * SCALE + span * 1000 * angle;
        if (num < 0) num = 0;
        return 22'((num + SCALE / 2) / SCALE);
    endfunction

    function automatic void push_step(int angle, bit drv, longint w, bit lst);
        t_step s;
        s.angle   = angle[11:0];
        s.duty    = duty_for(angle);
        s.drive   = drv;
        s.wait_ms = 17'(w);
        s.lst     = lst;
        pending_steps = {pending_steps, s};
    endfunction

    function automatic void plan_slew_steps(logic signed [12:0] raw);
        int     tgt, diff, mag, lim, stp, n;
        bit     lst;
        longint w;
        tgt = raw;
        if (tgt < 0) tgt = 0;
        if (tgt > SCALE) tgt = SCALE;
        diff = tgt - servo_angle;
        mag  = (diff < 0) ? -diff : diff;
        n    = 0;
        if (slew_step_reg != 0) begin
            lim = (slew_step_reg < SLEW_FLOOR) ? SLEW_FLOOR : int'(slew_step_reg);
            if (mag <= BAND) begin
                push_step(servo_angle, 1'b0, longint'(settle_wait_reg), 1'b1);
            end else begin
                while (mag > BAND && n < MAX_RUN) begin
                    stp = diff;
                    if (stp > lim) stp = lim;
                    if (stp < -lim) stp = -lim;
                    servo_angle += stp;
                    diff = tgt - servo_angle;
                    mag  = (diff < 0) ? -diff : diff;
                    lst  = (mag <= BAND) || (n == MAX_RUN - 1);
                    w    = longint'(slew_wait_reg);
                    if (lst) w += longint'(settle_wait_reg);
                    push_step(servo_angle, 1'b1, w, lst);
                    n++;
                end
            end
        end else begin
            w = longint'(settle_wait_reg) + ((longint'(ms_per_deg_reg) * mag) >> 12);
            if (w > longint'(max_move_reg)) w = longint'(max_move_reg);
            servo_angle = tgt;
            push_step(servo_angle, 1'b1, w, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_step seen, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_step_angle, o_duty_ns, o_drive, o_wait_ms, o_last};
            if (pending_steps.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected step: angle=%0d duty=%0d drive=%0d wait=%0d last=%0d",
                             seen.angle, seen.duty, seen.drive, seen.wait_ms, seen.lst);
                mismatch_count++;
            end else begin
                want = pending_steps.pop_front();
                if (seen !== want) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display({"step mismatch: want angle=%0d duty=%0d drive=%0d wait=%0d ",
                                  "last=%0d, got angle=%0d duty=%0d drive=%0d wait=%0d last=%0d"},
                                 want.angle, want.duty, want.drive, want.wait_ms, want.lst,
                                 seen.angle, seen.duty, seen.drive, seen.wait_ms, seen.lst);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_target(input logic signed [12:0] tgt);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_target_angle <= tgt;
        do @(posedge i_clk); while (o_in_stall);
        plan_slew_steps(tgt);
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            sslp_pkg::CFG_SLEW_STEP:   slew_step_reg   = val[11:0];
            sslp_pkg::CFG_SLEW_WAIT:   slew_wait_reg   = val;
            sslp_pkg::CFG_SETTLE_WAIT: settle_wait_reg = val;
            sslp_pkg::CFG_MS_PER_DEG:  ms_per_deg_reg  = val;
            sslp_pkg::CFG_MAX_MOVE:    max_move_reg    = val;
            sslp_pkg::CFG_MIN_PULSE:   min_pulse_reg   = val[11:0];
            sslp_pkg::CFG_MAX_PULSE:   max_pulse_reg   = val[11:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_setting(logic [2:0] idx);
        int          r;
        logic [15:0] v;
        r = $urandom_range(7);
        if (idx == sslp_pkg::CFG_SLEW_STEP) begin
            if (r < 2)       v = '0;
            else if (r == 2) v = 16'($urandom_range(1, 60));
            else if (r < 5)  v = 16'($urandom_range(45, 400));
            else if (r == 5) v = 16'($urandom_range(400, 2880));
            else if (r == 6) v = 16'(sslp_pkg::FULL_SCALE);
            else             v = 16'($urandom);
        end else if (idx == sslp_pkg::CFG_MIN_PULSE || idx == sslp_pkg::CFG_MAX_PULSE) begin
            if (r == 0)      v = '0;
            else if (r == 1) v = 16'd4095;
            else if (r == 2) v = 16'($urandom);
            else             v = 16'($urandom_range(0, 4000));
        end else begin
            if (r == 0)      v = '0;
            else if (r == 1) v = 16'hFFFF;
            else if (r < 5)  v = 16'($urandom_range(0, 300));
            else             v = 16'($urandom);
        end
        return v;
    endfunction

    task automatic randomize_regs();
        for (int k = int'(sslp_pkg::CFG_SLEW_STEP); k <= int'(sslp_pkg::CFG_MAX_PULSE); k++)
            write_reg(3'(k), pick_setting(3'(k)));
    endtask

    function automatic logic signed [12:0] pick_target();
        int r;
        r = $urandom_range(9);
        if (r < 6) return 13'($urandom_range(0, SCALE));
        if (r < 8) return 13'(servo_angle + int'($urandom_range(0, 24)) - 12);
        if (r == 8) return 13'($urandom);
        case ($urandom_range(3))
            0:       return -13'sd4096;
            1:       return 13'sd4095;
            2:       return 13'sd0;
            default: return 13'(SCALE);
        endcase
    endfunction

    task automatic test_unslewed_extremes();
        send_target(-13'sd4096);
        send_target(13'sd4095);
        send_target(13'sd2880);
        send_target(13'sd0);
        send_target(13'sd1440);
        send_target(13'sd1440);
        send_target(-13'sd1);
        send_target(13'sd2881);
    endtask

    task automatic test_small_step_runs();
        drain_requests();
        write_reg(sslp_pkg::CFG_SLEW_STEP, 16'd1);
        write_reg(sslp_pkg::CFG_SLEW_WAIT, 16'd0);
        write_reg(sslp_pkg::CFG_SETTLE_WAIT, 16'hFFFF);
        write_reg(sslp_pkg::CFG_MIN_PULSE, 16'd4095);
        write_reg(sslp_pkg::CFG_MAX_PULSE, 16'd0);
        send_target(13'sd0);
        send_target(13'sd8);
        send_target(13'sd9);
        send_target(13'sd2880);
        send_target(13'sd2875);
        send_target(13'sd2870);
    endtask

    task automatic test_wide_step_runs();
        drain_requests();
        write_reg(sslp_pkg::CFG_SLEW_STEP, 16'd2880);
        write_reg(sslp_pkg::CFG_SLEW_WAIT, 16'hFFFF);
        write_reg(sslp_pkg::CFG_MIN_PULSE, 16'd0);
        write_reg(sslp_pkg::CFG_MAX_PULSE, 16'd4095);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_target(13'sd0);
        send_target(13'sd2880);
        send_target(13'sd1440);
        send_target(13'sd1448);
    endtask

    task automatic test_move_time_limits();
        drain_requests();
        write_reg(sslp_pkg::CFG_SLEW_STEP, 16'hF000);
        write_reg(sslp_pkg::CFG_MS_PER_DEG, 16'hFFFF);
        write_reg(sslp_pkg::CFG_MAX_MOVE, 16'hFFFF);
        write_reg(sslp_pkg::CFG_SETTLE_WAIT, 16'd0);
        send_target(13'sd0);
        send_target(13'sd2880);
        drain_requests();
        write_reg(sslp_pkg::CFG_MAX_MOVE, 16'd0);
        send_target(13'sd1000);
    endtask

    task automatic test_random_phase(input int snd_pct, input int stl_pct, input int count);
        drain_requests();
        sender_idle_pct = snd_pct;
        recv_stall_pct  = stl_pct;
        randomize_regs();
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain_requests();
                randomize_regs();
            end
            send_target(pick_target());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unslewed_extremes();
        test_small_step_runs();
        test_wide_step_runs();
        test_move_time_limits();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(75, 0, PHASE_ITEMS);
        test_random_phase(0, 75, PHASE_ITEMS);
        test_random_phase(22, 22, PHASE_ITEMS);
        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/sslp_pkg.sv
design/servo_slew_limiter_pwm_core.sv
dv/testbench.sv
